// File: rtl/core/fcbu_pkg.sv
package fcbu_pkg;

    localparam int DATA_W = 16;
    localparam int IDX_W = 8;

    localparam logic [IDX_W-1:0] REG_BURN_RATE = 8'd0;
    localparam logic [IDX_W-1:0] REG_SMOKE_GAIN = 8'd1;
    localparam logic [IDX_W-1:0] REG_IGNITION_TEMP = 8'd2;
    localparam logic [IDX_W-1:0] REG_PEAK_TEMP = 8'd3;
    localparam logic [IDX_W-1:0] REG_TIME_STEP = 8'd4;
    localparam logic [IDX_W-1:0] REG_SMOKE_RED = 8'd5;
    localparam logic [IDX_W-1:0] REG_SMOKE_GREEN = 8'd6;
    localparam logic [IDX_W-1:0] REG_SMOKE_BLUE = 8'd7;

    localparam logic [DATA_W-1:0] RST_BURN_RATE = 16'd3072;
    localparam logic [DATA_W-1:0] RST_SMOKE_GAIN = 16'd4096;
    localparam logic [DATA_W-1:0] RST_IGNITION_TEMP = 16'd5120;
    localparam logic [DATA_W-1:0] RST_PEAK_TEMP = 16'd7168;
    localparam logic [DATA_W-1:0] RST_TIME_STEP = 16'd410;
    localparam logic [DATA_W-1:0] RST_SMOKE_COLOR = 16'd2867;

    // Reciprocal of ten for inputs below 2**22, exact after the shift.
    localparam logic [21:0] RECIP_TEN = 22'd3355444;
    localparam int RECIP_SH = 25;

    localparam int QUO_W = 16;
    localparam int RX_DIV_W = 16;
    localparam int COL_DIV_W = 18;
    localparam int SQRT_RAD_W = 28;
    localparam int SQRT_ROOT_W = 14;

    localparam int PIPE_DEPTH = 36;
    localparam int SIDE_DLY = 26;
    localparam int COL_DLY = 11;
    localparam int RNEW_DLY = 14;

    typedef struct packed {
        logic [DATA_W-1:0] fuel;
        logic [DATA_W-1:0] dens;
        logic [DATA_W-1:0] react;
        logic [DATA_W-1:0] heat;
        logic [DATA_W-1:0] red;
        logic [DATA_W-1:0] green;
        logic [DATA_W-1:0] blue;
        logic              border;
    } raw_t;

    typedef struct packed {
        raw_t              raw;
        logic [DATA_W-1:0] fnew;
        logic [DATA_W-1:0] dnew;
        logic              emit_nz;
        logic              sel_div;
        logic [2:0]        ovf;
        logic [DATA_W-1:0] low_r;
        logic [DATA_W-1:0] low_g;
        logic [DATA_W-1:0] low_b;
    } side_t;

endpackage

// File: rtl/core/fcbu_delay.sv
module fcbu_delay #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             en,
    input  logic [WIDTH-1:0] din,
    output logic [WIDTH-1:0] dout
);

    logic [WIDTH-1:0] data_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg[0] <= din;
            for (int i = 1; i < DEPTH; i++)
            begin
                data_reg[i] <= data_reg[i-1];
            end
        end
    end

    assign dout = data_reg[DEPTH-1];

endmodule

// File: rtl/core/fcbu_div.sv
module fcbu_div #(
    parameter int DIV_W = 16,
    parameter int QW = 16
) (
    input  logic                  clk,
    input  logic                  en,
    input  logic [DIV_W+QW-1:0]   num,
    input  logic [DIV_W-1:0]      div,
    output logic [QW-1:0]         quo
);

    logic [DIV_W-1:0] rem_reg [QW];
    logic [DIV_W-1:0] dv_reg [QW];
    logic [QW-1:0]    lo_reg [QW];
    logic [QW-1:0]    q_reg [QW];

    for (genvar i = 0; i < QW; i++)
    begin : g_stage
        logic [DIV_W-1:0] rem_in;
        logic [DIV_W-1:0] dv_in;
        logic [QW-1:0]    lo_in;
        logic [QW-1:0]    q_in;
        logic [DIV_W:0]   trial;
        logic             ge;
        logic [DIV_W:0]   diff;
        logic [DIV_W-1:0] rem_next;

        if (i == 0)
        begin : g_first
            assign rem_in = num[DIV_W+QW-1:QW];
            assign dv_in = div;
            assign lo_in = num[QW-1:0];
            assign q_in = '0;
        end
        else
        begin : g_next
            assign rem_in = rem_reg[i-1];
            assign dv_in = dv_reg[i-1];
            assign lo_in = lo_reg[i-1];
            assign q_in = q_reg[i-1];
        end

        assign trial = {rem_in, lo_in[QW-1]};
        assign ge = (trial >= {1'b0, dv_in});
        assign diff = trial - {1'b0, dv_in};
        assign rem_next = ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i] <= rem_next;
                dv_reg[i] <= dv_in;
                lo_reg[i] <= {lo_in[QW-2:0], 1'b0};
                q_reg[i] <= {q_in[QW-2:0], ge};
            end
        end
    end

    assign quo = q_reg[QW-1];

endmodule

// File: rtl/core/fcbu_sqrt.sv
module fcbu_sqrt #(
    parameter int RAD_W = 28,
    parameter int ROOT_W = 14
) (
    input  logic              clk,
    input  logic              en,
    input  logic [RAD_W-1:0]  rad,
    output logic [ROOT_W-1:0] root
);

    localparam int REM_W = ROOT_W + 2;

    logic [REM_W-1:0]  rem_reg [ROOT_W];
    logic [ROOT_W-1:0] root_reg [ROOT_W];
    logic [RAD_W-1:0]  rad_reg [ROOT_W];

    for (genvar i = 0; i < ROOT_W; i++)
    begin : g_stage
        logic [REM_W-1:0]  rem_in;
        logic [ROOT_W-1:0] root_in;
        logic [RAD_W-1:0]  rad_in;
        logic [REM_W+1:0]  cur;
        logic [REM_W+1:0]  trial;
        logic [REM_W+1:0]  diff;
        logic              ge;

        if (i == 0)
        begin : g_first
            assign rem_in = '0;
            assign root_in = '0;
            assign rad_in = rad;
        end
        else
        begin : g_next
            assign rem_in = rem_reg[i-1];
            assign root_in = root_reg[i-1];
            assign rad_in = rad_reg[i-1];
        end

        assign cur = {rem_in, rad_in[RAD_W-1:RAD_W-2]};
        assign trial = {{(REM_W-ROOT_W){1'b0}}, root_in, 2'b01};
        assign ge = (cur >= trial);
        assign diff = cur - trial;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i] <= ge ? diff[REM_W-1:0] : cur[REM_W-1:0];
                root_reg[i] <= {root_in[ROOT_W-2:0], ge};
                rad_reg[i] <= {rad_in[RAD_W-3:0], 2'b00};
            end
        end
    end

    assign root = root_reg[ROOT_W-1];

endmodule

// File: rtl/core/fire_cell_burn_update.sv
// An accepted item travels to the output register alongside its bit in the valid shift register.
// Throughput: one cell per cycle; the pipeline holds as a whole while the output stalls.
// Depth comes from the bit-per-stage divider for the reaction ratio (16 stages)
// followed by the bit-pair-per-stage square root for the flame (14 stages).
// Reset clears all valid bits and loads the default register values.
module fire_cell_burn_update (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         item_valid,
    output logic                         item_stall,
    input  logic [15:0]                  fuel_in,
    input  logic [15:0]                  density_in,
    input  logic [15:0]                  reaction_in,
    input  logic signed [15:0]           heat_in,
    input  logic [15:0]                  red_in,
    input  logic [15:0]                  green_in,
    input  logic [15:0]                  blue_in,
    input  logic                         border_cell,
    output logic                         result_valid,
    input  logic                         result_stall,
    output logic [15:0]                  fuel_out,
    output logic [15:0]                  density_out,
    output logic [15:0]                  reaction_out,
    output logic signed [15:0]           heat_out,
    output logic [15:0]                  red_out,
    output logic [15:0]                  green_out,
    output logic [15:0]                  blue_out,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [fcbu_pkg::IDX_W-1:0]   cfg_index,
    input  logic [15:0]                  cfg_data
);

    logic [15:0] burn_rate_reg, smoke_gain_reg, ign_reg, peak_reg, tstep_reg;
    logic [15:0] smoke_r_reg, smoke_g_reg, smoke_b_reg;
    logic        en;
    logic [fcbu_pkg::PIPE_DEPTH-1:0] vld_reg;

    fcbu_pkg::raw_t raw0_reg, raw1_reg, raw2_reg, raw3_reg, raw4_reg, raw5_reg, raw6_reg;
    logic [31:0] amtp_reg;
    logic [15:0] fnew2_reg, fnew3_reg, fnew4_reg, fnew5_reg, fnew6_reg;
    logic [15:0] burned2_reg;
    logic [12:0] b2_reg;
    logic [31:0] rf_reg;
    logic [15:0] fdiv_reg;
    logic [28:0] tb_reg;
    logic [44:0] p_reg;
    logic [42:0] em_reg;
    logic [15:0] dnew6_reg;
    logic        emit_nz6_reg;
    logic [17:0] s6_reg;
    logic [33:0] xr_reg, xg_reg, xb_reg;
    fcbu_pkg::side_t side7_reg, side_dly;

    logic [15:0] rnew_q, rnew_dly;
    logic [13:0] flame;
    logic [15:0] qr, qg, qb;
    logic [47:0] col_dly;

    logic [15:0] fuel35_reg, dens35_reg, react35_reg, heat35_reg;
    logic [15:0] red35_reg, grn35_reg, blu35_reg;
    logic        border35_reg, flame_nz35_reg;
    logic signed [32:0] hn35_reg;

    logic [15:0] fuel_out_reg, dens_out_reg, react_out_reg, heat_out_reg;
    logic [15:0] red_out_reg, grn_out_reg, blu_out_reg;

    assign en = !(vld_reg[fcbu_pkg::PIPE_DEPTH-1] && result_stall);
    assign item_stall = !en;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            burn_rate_reg <= fcbu_pkg::RST_BURN_RATE;
            smoke_gain_reg <= fcbu_pkg::RST_SMOKE_GAIN;
            ign_reg <= fcbu_pkg::RST_IGNITION_TEMP;
            peak_reg <= fcbu_pkg::RST_PEAK_TEMP;
            tstep_reg <= fcbu_pkg::RST_TIME_STEP;
            smoke_r_reg <= fcbu_pkg::RST_SMOKE_COLOR;
            smoke_g_reg <= fcbu_pkg::RST_SMOKE_COLOR;
            smoke_b_reg <= fcbu_pkg::RST_SMOKE_COLOR;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                fcbu_pkg::REG_BURN_RATE: burn_rate_reg <= cfg_data;
                fcbu_pkg::REG_SMOKE_GAIN: smoke_gain_reg <= cfg_data;
                fcbu_pkg::REG_IGNITION_TEMP: ign_reg <= cfg_data;
                fcbu_pkg::REG_PEAK_TEMP: peak_reg <= cfg_data;
                fcbu_pkg::REG_TIME_STEP: tstep_reg <= cfg_data;
                fcbu_pkg::REG_SMOKE_RED: smoke_r_reg <= cfg_data;
                fcbu_pkg::REG_SMOKE_GREEN: smoke_g_reg <= cfg_data;
                fcbu_pkg::REG_SMOKE_BLUE: smoke_b_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[fcbu_pkg::PIPE_DEPTH-2:0], item_valid};
        end
    end

    // Front end: burn amount, new fuel, and the operands of the emission product.
    logic [19:0] amt;
    logic [15:0] fnew_c;
    logic [12:0] b2_c;
    logic [15:0] emit_c;
    logic        emit_hi;
    logic [16:0] emit17;
    logic [17:0] s_c;

    always_comb
    begin
        amt = amtp_reg[31:12];
        fnew_c = (amt >= {4'b0, raw1_reg.fuel}) ? 16'd0 : raw1_reg.fuel - amt[15:0];
        if (raw1_reg.fuel < 16'd4096)
        begin
            b2_c = 13'((13'd4096 - raw1_reg.fuel[12:0]) >> 1) + 13'd2048;
        end
        else
        begin
            b2_c = 13'd2048;
        end
        emit17 = em_reg[fcbu_pkg::RECIP_SH+16:fcbu_pkg::RECIP_SH];
        emit_c = emit17[15:0];
        emit_hi = emit17[16];
        s_c = {2'b00, raw5_reg.dens} + {1'b0, emit17};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            raw0_reg <= '{fuel_in, density_in, reaction_in, heat_in,
                          red_in, green_in, blue_in, border_cell};
            raw1_reg <= raw0_reg;
            amtp_reg <= burn_rate_reg * tstep_reg;

            raw2_reg <= raw1_reg;
            fnew2_reg <= fnew_c;
            burned2_reg <= raw1_reg.fuel - fnew_c;
            b2_reg <= b2_c;

            raw3_reg <= raw2_reg;
            fnew3_reg <= fnew2_reg;
            rf_reg <= raw2_reg.react * fnew2_reg;
            fdiv_reg <= (raw2_reg.fuel == 16'd0) ? 16'd1 : raw2_reg.fuel;
            tb_reg <= b2_reg * burned2_reg;

            raw4_reg <= raw3_reg;
            fnew4_reg <= fnew3_reg;
            p_reg <= tb_reg * smoke_gain_reg;

            raw5_reg <= raw4_reg;
            fnew5_reg <= fnew4_reg;
            em_reg <= p_reg[44:24] * fcbu_pkg::RECIP_TEN;

            raw6_reg <= raw5_reg;
            fnew6_reg <= fnew5_reg;
            dnew6_reg <= (s_c > 18'd4096) ? 16'd4096 : s_c[15:0];
            emit_nz6_reg <= emit_hi || (emit_c != 16'd0);
            s6_reg <= s_c;
            xr_reg <= {2'b00, raw5_reg.red, 12'd0} + 34'(smoke_r_reg) * 34'(emit17);
            xg_reg <= {2'b00, raw5_reg.green, 12'd0} + 34'(smoke_g_reg) * 34'(emit17);
            xb_reg <= {2'b00, raw5_reg.blue, 12'd0} + 34'(smoke_b_reg) * 34'(emit17);

            side7_reg.raw <= raw6_reg;
            side7_reg.fnew <= fnew6_reg;
            side7_reg.dnew <= dnew6_reg;
            side7_reg.emit_nz <= emit_nz6_reg;
            side7_reg.sel_div <= (s6_reg > 18'd4096);
            side7_reg.ovf <= {xb_reg[33:16] >= s6_reg, xg_reg[33:16] >= s6_reg,
                              xr_reg[33:16] >= s6_reg};
            side7_reg.low_r <= (xr_reg[33:28] != 6'd0) ? 16'hFFFF : xr_reg[27:12];
            side7_reg.low_g <= (xg_reg[33:28] != 6'd0) ? 16'hFFFF : xg_reg[27:12];
            side7_reg.low_b <= (xb_reg[33:28] != 6'd0) ? 16'hFFFF : xb_reg[27:12];
        end
    end

    fcbu_div #(.DIV_W(fcbu_pkg::RX_DIV_W), .QW(fcbu_pkg::QUO_W)) u_rx_div (
        .clk(clk), .en(en), .num(rf_reg), .div(fdiv_reg), .quo(rnew_q)
    );

    fcbu_sqrt #(.RAD_W(fcbu_pkg::SQRT_RAD_W), .ROOT_W(fcbu_pkg::SQRT_ROOT_W)) u_sqrt (
        .clk(clk), .en(en), .rad({rnew_q[15:0], 12'd0}), .root(flame)
    );

    fcbu_delay #(.WIDTH(16), .DEPTH(fcbu_pkg::RNEW_DLY)) u_rnew_dly (
        .clk(clk), .en(en), .din(rnew_q), .dout(rnew_dly)
    );

    fcbu_div #(.DIV_W(fcbu_pkg::COL_DIV_W), .QW(fcbu_pkg::QUO_W)) u_red_div (
        .clk(clk), .en(en), .num(xr_reg), .div(s6_reg), .quo(qr)
    );

    fcbu_div #(.DIV_W(fcbu_pkg::COL_DIV_W), .QW(fcbu_pkg::QUO_W)) u_green_div (
        .clk(clk), .en(en), .num(xg_reg), .div(s6_reg), .quo(qg)
    );

    fcbu_div #(.DIV_W(fcbu_pkg::COL_DIV_W), .QW(fcbu_pkg::QUO_W)) u_blue_div (
        .clk(clk), .en(en), .num(xb_reg), .div(s6_reg), .quo(qb)
    );

    fcbu_delay #(.WIDTH(48), .DEPTH(fcbu_pkg::COL_DLY)) u_col_dly (
        .clk(clk), .en(en), .din({qr, qg, qb}), .dout(col_dly)
    );

    fcbu_delay #(.WIDTH($bits(fcbu_pkg::side_t)), .DEPTH(fcbu_pkg::SIDE_DLY)) u_side_dly (
        .clk(clk), .en(en), .din(side7_reg), .dout(side_dly)
    );

    // Back end: color selection, heat line, and the border bypass.
    logic [15:0] col_r, col_g, col_b;
    logic signed [16:0] tdiff;
    logic signed [31:0] hprod;
    logic signed [20:0] hq;
    logic [15:0] heat_sat;

    always_comb
    begin
        if (!side_dly.emit_nz)
        begin
            col_r = side_dly.raw.red;
            col_g = side_dly.raw.green;
            col_b = side_dly.raw.blue;
        end
        else if (!side_dly.sel_div)
        begin
            col_r = side_dly.low_r;
            col_g = side_dly.low_g;
            col_b = side_dly.low_b;
        end
        else
        begin
            col_r = side_dly.ovf[0] ? 16'hFFFF : col_dly[47:32];
            col_g = side_dly.ovf[1] ? 16'hFFFF : col_dly[31:16];
            col_b = side_dly.ovf[2] ? 16'hFFFF : col_dly[15:0];
        end
        tdiff = $signed({1'b0, peak_reg}) - $signed({1'b0, ign_reg});
        hprod = $signed({1'b0, flame}) * tdiff;
        hq = hn35_reg[32:12];
        if (hq > 21'sd32767)
        begin
            heat_sat = 16'h7FFF;
        end
        else if (hq < -21'sd32768)
        begin
            heat_sat = 16'h8000;
        end
        else
        begin
            heat_sat = hq[15:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            border35_reg <= side_dly.raw.border;
            fuel35_reg <= side_dly.raw.border ? side_dly.raw.fuel : side_dly.fnew;
            dens35_reg <= side_dly.raw.border ? side_dly.raw.dens : side_dly.dnew;
            react35_reg <= side_dly.raw.border ? side_dly.raw.react : rnew_dly;
            red35_reg <= side_dly.raw.border ? side_dly.raw.red : col_r;
            grn35_reg <= side_dly.raw.border ? side_dly.raw.green : col_g;
            blu35_reg <= side_dly.raw.border ? side_dly.raw.blue : col_b;
            heat35_reg <= side_dly.raw.heat;
            flame_nz35_reg <= (flame != 14'd0);
            hn35_reg <= $signed({4'b0000, ign_reg, 12'd0}) + 33'(hprod);

            fuel_out_reg <= fuel35_reg;
            dens_out_reg <= dens35_reg;
            react_out_reg <= react35_reg;
            red_out_reg <= red35_reg;
            grn_out_reg <= grn35_reg;
            blu_out_reg <= blu35_reg;
            heat_out_reg <= (!border35_reg && flame_nz35_reg) ? heat_sat : heat35_reg;
        end
    end

    assign result_valid = vld_reg[fcbu_pkg::PIPE_DEPTH-1];
    assign fuel_out = fuel_out_reg;
    assign density_out = dens_out_reg;
    assign reaction_out = react_out_reg;
    assign heat_out = heat_out_reg;
    assign red_out = red_out_reg;
    assign green_out = grn_out_reg;
    assign blue_out = blu_out_reg;

endmodule
